// ===== rtl/balancing_number_mod_top_defines.svh =====
// Assertion macros shared by the balancing-number RTL.
`ifndef BALANCING_NUMBER_MOD_TOP_DEFINES_SVH
`define BALANCING_NUMBER_MOD_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BNM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define BNM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bnm_pkg.sv =====
// Shared constants and modular add/subtract helpers for the balancing-number block.
package bnm_pkg;

   // Datapath width of modulus and residues
   localparam int DATA_W = 64;
   // Default number of index bits that take part
   localparam int INDEX_WIDTH_DEF = 64;

   // (a + b) mod m for a, b < m
   function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[DATA_W-1:0];
   endfunction

   // (a - b) mod m for a, b < m; wraparound gives m - (b - a) when a < b
   function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
      logic [DATA_W-1:0] d;
      d = a - b;
      if (a < b) begin
         d = d + m;
      end
      return d;
   endfunction

endpackage

// ===== rtl/balancing_number_mod_top.sv =====
// Top level: balancing-number term U_n mod m by fast doubling over a bit-serial multiplier.
//
//   channel   ports                                  handshake
//   request   req_index, req_modulus                 start & !busy
//   response  rsp_term                               rsp_valid, one cycle
//
// Leading zero bits of the index are skipped at one cycle each.
// Each remaining index bit takes a run of add/subtract states plus three
// modular multiplies, each of which doubles for every multiplier bit and adds
// the multiplicand where that bit is set, plus launch and handoff.
// Zero index or zero modulus answers next cycle.
// Synchronous reset returns to idle with no response pending.
// The response strobe cannot be held off; busy stays high until it is issued.
`include "balancing_number_mod_top_defines.svh"

module balancing_number_mod_top
   import bnm_pkg::*;
#(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [INDEX_WIDTH-1:0] req_index,
   input  logic [DATA_W-1:0]      req_modulus,
   output logic                   rsp_valid,
   output logic [DATA_W-1:0]      rsp_term
);

   localparam int NCNT_W = $clog2(INDEX_WIDTH + 1);

   // Sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_SCAN  = 5'd1;
   localparam logic [4:0] ST_TV    = 5'd2;
   localparam logic [4:0] ST_U2    = 5'd3;
   localparam logic [4:0] ST_U4    = 5'd4;
   localparam logic [4:0] ST_U6    = 5'd5;
   localparam logic [4:0] ST_T     = 5'd6;
   localparam logic [4:0] ST_ME_GO = 5'd7;
   localparam logic [4:0] ST_ME_W  = 5'd8;
   localparam logic [4:0] ST_MV_GO = 5'd9;
   localparam logic [4:0] ST_MV_W  = 5'd10;
   localparam logic [4:0] ST_MU_GO = 5'd11;
   localparam logic [4:0] ST_MU_W  = 5'd12;
   localparam logic [4:0] ST_ODD   = 5'd13;
   localparam logic [4:0] ST_O2    = 5'd14;
   localparam logic [4:0] ST_O4    = 5'd15;
   localparam logic [4:0] ST_O6    = 5'd16;
   localparam logic [4:0] ST_NV    = 5'd17;

   logic [4:0]             state_ff, state_in;
   logic [INDEX_WIDTH-1:0] n_ff, n_in;
   logic [NCNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_W-1:0]      m_ff, m_in;
   logic [DATA_W-1:0]      u_ff, u_in;
   logic [DATA_W-1:0]      v_ff, v_in;
   logic [DATA_W-1:0]      tv_ff, tv_in;
   logic [DATA_W-1:0]      x_ff, x_in;
   logic [DATA_W-1:0]      y_ff, y_in;
   logic [DATA_W-1:0]      e_ff, e_in;
   logic [DATA_W-1:0]      o_ff, o_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_term_ff, rsp_term_in;

   logic                   accept;
   logic                   cur_bit;
   logic                   last_bit;
   logic [DATA_W-1:0]      alu_a, alu_b, alu_r;
   logic                   alu_sub;
   logic                   mul_start;
   logic [DATA_W-1:0]      mul_a, mul_b, mul_p;
   logic                   mul_done;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign cur_bit  = n_ff[INDEX_WIDTH-1];
   assign last_bit = (cnt_ff == NCNT_W'(1));

   // Shared modular add/subtract: operand select by state
   always_comb begin
      alu_a   = u_ff;
      alu_b   = u_ff;
      alu_sub = 1'b0;
      case (state_ff)
         ST_TV: begin
            alu_a = v_ff;
            alu_b = v_ff;
         end
         ST_U2: begin
            alu_a = u_ff;
            alu_b = u_ff;
         end
         ST_U4, ST_O4: begin
            alu_a = x_ff;
            alu_b = x_ff;
         end
         ST_U6, ST_O6: begin
            alu_a = x_ff;
            alu_b = y_ff;
         end
         ST_T: begin
            alu_a   = tv_ff;
            alu_b   = y_ff;
            alu_sub = 1'b1;
         end
         ST_ODD: begin
            alu_a   = x_ff;
            alu_b   = y_ff;
            alu_sub = 1'b1;
         end
         ST_O2: begin
            alu_a = o_ff;
            alu_b = o_ff;
         end
         ST_NV: begin
            alu_a   = y_ff;
            alu_b   = e_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = u_ff;
            alu_b   = u_ff;
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_r = alu_sub ? mod_sub(alu_a, alu_b, m_ff) : mod_add(alu_a, alu_b, m_ff);

   // Multiplier launch and operand select
   always_comb begin
      mul_start = 1'b0;
      mul_a     = u_ff;
      mul_b     = u_ff;
      case (state_ff)
         ST_ME_GO: begin
            mul_start = 1'b1;
            mul_a     = u_ff;
            mul_b     = x_ff;
         end
         ST_MV_GO: begin
            mul_start = 1'b1;
            mul_a     = v_ff;
            mul_b     = v_ff;
         end
         ST_MU_GO: begin
            mul_start = 1'b1;
            mul_a     = u_ff;
            mul_b     = u_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   bnm_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .mul_start (mul_start),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_m     (m_ff),
      .mul_done  (mul_done),
      .mul_p     (mul_p)
   );

   // Sequencer: one doubling step per index bit, MSB first
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      tv_in        = tv_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      o_in         = o_ff;
      rsp_valid_in = 1'b0;
      rsp_term_in  = rsp_term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in   = req_index;
               m_in   = req_modulus;
               cnt_in = NCNT_W'(INDEX_WIDTH);
               u_in   = '0;
               v_in   = (req_modulus == DATA_W'(1)) ? '0 : DATA_W'(1);
               if (req_modulus == '0 || req_index == '0) begin
                  // trivial transaction: answer zero at once
                  rsp_valid_in = 1'b1;
                  rsp_term_in  = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!cur_bit && !last_bit) begin
               n_in   = {n_ff[INDEX_WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff - NCNT_W'(1);
            end else begin
               state_in = ST_TV;
            end
         end
         ST_TV: begin
            tv_in    = alu_r;
            state_in = ST_U2;
         end
         ST_U2: begin
            x_in     = alu_r;
            state_in = ST_U4;
         end
         ST_U4: begin
            y_in     = alu_r;
            state_in = ST_U6;
         end
         ST_U6: begin
            y_in     = alu_r;
            state_in = ST_T;
         end
         ST_T: begin
            x_in     = alu_r;
            state_in = ST_ME_GO;
         end
         ST_ME_GO: begin
            state_in = ST_ME_W;
         end
         ST_ME_W: begin
            if (mul_done) begin
               e_in     = mul_p;
               state_in = ST_MV_GO;
            end
         end
         ST_MV_GO: begin
            state_in = ST_MV_W;
         end
         ST_MV_W: begin
            if (mul_done) begin
               x_in     = mul_p;
               state_in = ST_MU_GO;
            end
         end
         ST_MU_GO: begin
            state_in = ST_MU_W;
         end
         ST_MU_W: begin
            if (mul_done) begin
               y_in     = mul_p;
               state_in = ST_ODD;
            end
         end
         ST_ODD: begin
            o_in = alu_r;
            if (cur_bit) begin
               state_in = ST_O2;
            end else begin
               // bit clear: (U_2k, U_2k+1)
               u_in   = e_ff;
               v_in   = alu_r;
               n_in   = {n_ff[INDEX_WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff - NCNT_W'(1);
               if (last_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_term_in  = e_ff;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_TV;
               end
            end
         end
         ST_O2: begin
            x_in     = alu_r;
            state_in = ST_O4;
         end
         ST_O4: begin
            y_in     = alu_r;
            state_in = ST_O6;
         end
         ST_O6: begin
            y_in     = alu_r;
            state_in = ST_NV;
         end
         ST_NV: begin
            // bit set: (U_2k+1, 6*U_2k+1 - U_2k)
            u_in   = o_ff;
            v_in   = alu_r;
            n_in   = {n_ff[INDEX_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - NCNT_W'(1);
            if (last_bit) begin
               rsp_valid_in = 1'b1;
               rsp_term_in  = o_ff;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_TV;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      m_ff        <= m_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      tv_ff       <= tv_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      e_ff        <= e_in;
      o_ff        <= o_in;
      rsp_term_ff <= rsp_term_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_term  = rsp_term_ff;

   // Checks
   `BNM_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid,
      "accepted transaction neither running nor answered")
   `BNM_ASSERT_IMPL(a_term_reduced, clock, reset, rsp_valid,
      (m_ff == '0) || (rsp_term < m_ff), "response term not reduced")
   `BNM_ASSERT_IMPL(a_pair_reduced, clock, reset, busy,
      (u_ff < m_ff) && (v_ff < m_ff), "doubling pair out of range")
   `BNM_ASSERT_IMPL(a_mul_done_wait, clock, reset, mul_done,
      (state_ff == ST_ME_W) || (state_ff == ST_MV_W) || (state_ff == ST_MU_W),
      "multiplier result with no consumer")

endmodule

// ===== rtl/bnm_mulmod.sv =====
// Bit-serial modular multiplier: double-and-add from the top bit of the multiplier.
module bnm_mulmod
   import bnm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              mul_start,
   input  logic [DATA_W-1:0] mul_a,
   input  logic [DATA_W-1:0] mul_b,
   input  logic [DATA_W-1:0] mul_m,
   output logic              mul_done,
   output logic [DATA_W-1:0] mul_p
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic              run_ff, run_in;
   logic              phase_ff, phase_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] m_ff, m_in;
   logic [DATA_W-1:0] add_r;

   // One shared modular adder: doubles in phase 0, adds the multiplicand in phase 1
   assign add_r = mod_add(acc_ff, phase_ff ? a_ff : acc_ff, m_ff);

   // Next-state logic
   always_comb begin
      run_in   = run_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      if (mul_start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         cnt_in   = CNT_W'(DATA_W);
         acc_in   = '0;
         a_in     = mul_a;
         b_in     = mul_b;
         m_in     = mul_m;
      end else if (run_ff) begin
         acc_in = add_r;
         if (!phase_ff && b_ff[DATA_W-1]) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            b_in     = {b_ff[DATA_W-2:0], 1'b0};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         run_ff   <= run_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign mul_done = done_ff;
   assign mul_p    = acc_ff;

endmodule
